// File: sv/flv_avc_video_tag_parser_core_macros.svh
// Assertion macros for the FLV AVC video tag parser core.
`ifndef FLV_AVC_VIDEO_TAG_PARSER_CORE_MACROS_SVH
`define FLV_AVC_VIDEO_TAG_PARSER_CORE_MACROS_SVH

// same-cycle implication
`define FLVAVC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("flvavc assertion failed");

// next-cycle implication
`define FLVAVC_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("flvavc assertion failed");

`endif

// File: sv/flvavc_pkg.sv
// Shared types and constants of the FLV AVC video tag parser.
`default_nettype none
package flvavc_pkg;

    localparam logic [2:0] KIND_NALU     = 3'd0;
    localparam logic [2:0] KIND_CONFIG   = 3'd1;
    localparam logic [2:0] KIND_CODEC    = 3'd2;
    localparam logic [2:0] KIND_PKT_TYPE = 3'd3;
    localparam logic [2:0] KIND_TOO_LONG = 3'd4;

    localparam logic [3:0] AVC_CODEC      = 4'd7;
    localparam logic [4:0] IDR_TYPE       = 5'd5;
    localparam logic [2:0] LEN_SIZE_RESET = 3'd4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [2:0]         kind;
        logic [23:0]        nalu_length;
        logic [4:0]         nal_type;
        logic [31:0]        decode_time;
        logic signed [23:0] comp_offset;
        logic [7:0]         profile;
        logic [7:0]         level;
        logic [2:0]         prefix_size;
        logic [3:0]         frame_type;
    } res_t;

endpackage
`default_nettype wire

// File: sv/flvavc_front.sv
// Front end: tag body parser that classifies bytes and issues result records.
`default_nettype none
module flvavc_front (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               in_xfer,
    input  wire [7:0]         data_byte,
    input  wire               first_of_tag,
    input  wire [23:0]        tag_size,
    input  wire [31:0]        tag_timestamp,
    output logic              push,
    output flvavc_pkg::res_t  res
);
    import flvavc_pkg::*;

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_TYPE     = 4'd1;
    localparam logic [3:0] PH_OFS_CFG  = 4'd2;
    localparam logic [3:0] PH_OFS_NALU = 4'd3;
    localparam logic [3:0] PH_OFS_END  = 4'd4;
    localparam logic [3:0] PH_OFS_BAD  = 4'd5;
    localparam logic [3:0] PH_CFG      = 4'd6;
    localparam logic [3:0] PH_PREFIX   = 4'd7;
    localparam logic [3:0] PH_HEAD     = 4'd8;
    localparam logic [3:0] PH_SKIP     = 4'd9;

    localparam logic [7:0] PKT_CONFIG = 8'd0;
    localparam logic [7:0] PKT_NALU   = 8'd1;
    localparam logic [7:0] PKT_END    = 8'd2;

    localparam logic [23:0] POS_OFS_LAST = 24'd4;
    localparam logic [23:0] POS_PROFILE  = 24'd6;
    localparam logic [23:0] POS_LEVEL    = 24'd8;
    localparam logic [23:0] POS_LEN_SIZE = 24'd9;

    logic [3:0]  phase_reg, phase_next;
    logic [23:0] byte_index_reg, byte_index_next;
    logic [31:0] seg_rem_reg, seg_rem_next;
    logic [2:0]  length_size_reg, length_size_next;
    logic [31:0] nalu_acc_reg, nalu_acc_next;
    logic [2:0]  prefix_count_reg, prefix_count_next;
    logic [23:0] offset_reg, offset_next;
    logic [3:0]  frame_type_reg, frame_type_next;
    logic [7:0]  profile_reg, profile_next;
    logic [7:0]  level_reg, level_next;

    logic [23:0] rem;
    logic [31:0] acc_new;
    logic [2:0]  pc_new;
    logic [2:0]  kind;
    logic [23:0] nalu_len;
    logic [4:0]  ntype;

    always_comb begin
        phase_next        = phase_reg;
        byte_index_next   = byte_index_reg;
        seg_rem_next      = seg_rem_reg;
        length_size_next  = length_size_reg;
        nalu_acc_next     = nalu_acc_reg;
        prefix_count_next = prefix_count_reg;
        offset_next       = offset_reg;
        frame_type_next   = frame_type_reg;
        profile_next      = profile_reg;
        level_next        = level_reg;
        push     = 1'b0;
        kind     = KIND_NALU;
        nalu_len = 24'd0;
        ntype    = 5'd0;
        rem      = (tag_size > byte_index_reg) ? tag_size - byte_index_reg : 24'd0;
        acc_new  = '0;
        pc_new   = prefix_count_reg + 3'd1;

        if (in_xfer) begin
            if (first_of_tag) begin
                byte_index_next   = 24'd1;
                offset_next       = 24'd0;
                prefix_count_next = 3'd0;
                frame_type_next   = data_byte[7:4];
                if (data_byte[3:0] != AVC_CODEC) begin
                    phase_next = PH_IDLE;
                    push       = 1'b1;
                    kind       = KIND_CODEC;
                end else begin
                    phase_next = PH_TYPE;
                end
            end else if (phase_reg != PH_IDLE) begin
                if (byte_index_reg != '1) begin
                    byte_index_next = byte_index_reg + 24'd1;
                end
                case (phase_reg)
                    PH_TYPE: begin
                        offset_next = 24'd0;
                        case (data_byte)
                            PKT_CONFIG: phase_next = PH_OFS_CFG;
                            PKT_NALU:   phase_next = PH_OFS_NALU;
                            PKT_END:    phase_next = PH_OFS_END;
                            default:    phase_next = PH_OFS_BAD;
                        endcase
                    end
                    PH_OFS_CFG, PH_OFS_NALU, PH_OFS_END, PH_OFS_BAD: begin
                        offset_next = {offset_reg[15:0], data_byte};
                        if (byte_index_reg >= POS_OFS_LAST) begin
                            case (phase_reg)
                                PH_OFS_CFG: phase_next = PH_CFG;
                                PH_OFS_NALU: begin
                                    phase_next        = PH_PREFIX;
                                    prefix_count_next = 3'd0;
                                end
                                PH_OFS_END: phase_next = PH_IDLE;
                                default: begin
                                    phase_next = PH_IDLE;
                                    push       = 1'b1;
                                    kind       = KIND_PKT_TYPE;
                                end
                            endcase
                        end
                    end
                    PH_CFG: begin
                        if (byte_index_reg == POS_PROFILE) begin
                            profile_next = data_byte;
                        end else if (byte_index_reg == POS_LEVEL) begin
                            level_next = data_byte;
                        end else if (byte_index_reg >= POS_LEN_SIZE) begin
                            length_size_next = {1'b0, data_byte[1:0]} + 3'd1;
                            phase_next       = PH_IDLE;
                            push             = 1'b1;
                            kind             = KIND_CONFIG;
                        end
                    end
                    PH_PREFIX: begin
                        if (prefix_count_reg == 3'd0 && rem <= {21'd0, length_size_reg}) begin
                            phase_next = PH_IDLE;
                        end else begin
                            acc_new = (prefix_count_reg == 3'd0) ? {24'd0, data_byte}
                                                                 : {nalu_acc_reg[23:0], data_byte};
                            nalu_acc_next = acc_new;
                            if (pc_new < length_size_reg) begin
                                prefix_count_next = pc_new;
                            end else begin
                                prefix_count_next = 3'd0;
                                if (rem != 24'd0 && acc_new >= {8'd0, rem}) begin
                                    phase_next = PH_IDLE;
                                    push       = 1'b1;
                                    kind       = KIND_TOO_LONG;
                                end else if (acc_new == 32'd0) begin
                                    push     = 1'b1;
                                    nalu_len = {21'd0, length_size_reg};
                                end else begin
                                    phase_next = PH_HEAD;
                                end
                            end
                        end
                    end
                    PH_HEAD: begin
                        seg_rem_next      = nalu_acc_reg - 32'd1;
                        phase_next        = (seg_rem_next == 32'd0) ? PH_PREFIX : PH_SKIP;
                        prefix_count_next = 3'd0;
                        push              = 1'b1;
                        nalu_len          = nalu_acc_reg[23:0] + {21'd0, length_size_reg};
                        ntype             = data_byte[4:0];
                    end
                    PH_SKIP: begin
                        if (seg_rem_reg != 32'd0) begin
                            seg_rem_next = seg_rem_reg - 32'd1;
                        end
                        if (seg_rem_next == 32'd0) begin
                            phase_next        = PH_PREFIX;
                            prefix_count_next = 3'd0;
                        end
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
        end

        res.kind        = kind;
        res.nalu_length = nalu_len;
        res.nal_type    = ntype;
        res.decode_time = tag_timestamp;
        res.comp_offset = offset_next;
        res.profile     = profile_next;
        res.level       = level_next;
        res.prefix_size = length_size_next;
        res.frame_type  = frame_type_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            byte_index_reg   <= 24'd0;
            seg_rem_reg      <= 32'd0;
            length_size_reg  <= LEN_SIZE_RESET;
            nalu_acc_reg     <= 32'd0;
            prefix_count_reg <= 3'd0;
            offset_reg       <= 24'd0;
            frame_type_reg   <= 4'd0;
            profile_reg      <= 8'd0;
            level_reg        <= 8'd0;
        end else begin
            phase_reg        <= phase_next;
            byte_index_reg   <= byte_index_next;
            seg_rem_reg      <= seg_rem_next;
            length_size_reg  <= length_size_next;
            nalu_acc_reg     <= nalu_acc_next;
            prefix_count_reg <= prefix_count_next;
            offset_reg       <= offset_next;
            frame_type_reg   <= frame_type_next;
            profile_reg      <= profile_next;
            level_reg        <= level_next;
        end
    end

endmodule
`default_nettype wire

// File: sv/flvavc_queue.sv
// Small result queue between parser front end and output back end.
`default_nettype none
module flvavc_queue (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             push,
    input  flvavc_pkg::res_t                wdata,
    input  wire                             pop,
    output flvavc_pkg::res_t                rdata,
    output logic [flvavc_pkg::QUEUE_AW:0]   count
);
    import flvavc_pkg::*;

    res_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wptr_reg, rptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    assign rdata = mem[rptr_reg];
    assign count = count_reg;

endmodule
`default_nettype wire

// File: sv/flvavc_back.sv
// Back end: derives keyframe flag and presentation time, holds the output transfer.
`default_nettype none
module flvavc_back (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               q_nonempty,
    input  flvavc_pkg::res_t  q_data,
    output logic              pop,
    output logic              m_tvalid,
    input  wire               m_tready,
    output logic [143:0]      m_tdata,
    output logic [2:0]        m_tuser
);
    import flvavc_pkg::*;

    logic         valid_reg;
    logic [143:0] data_reg;
    logic [2:0]   kind_reg;
    logic [31:0]  present;
    logic         keyframe;

    assign pop      = q_nonempty && (!valid_reg || m_tready);
    assign present  = q_data.decode_time + {{8{q_data.comp_offset[23]}}, q_data.comp_offset};
    assign keyframe = (q_data.kind == KIND_NALU) && (q_data.nal_type == IDR_TYPE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            kind_reg <= q_data.kind;
            data_reg <= {3'd0, q_data.frame_type, q_data.prefix_size, q_data.level,
                         q_data.profile, present, q_data.comp_offset, q_data.decode_time,
                         keyframe, q_data.nal_type, q_data.nalu_length};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = kind_reg;

endmodule
`default_nettype wire

// File: sv/flv_avc_video_tag_parser_core.sv
// A result passes the result queue, then the output register that drives m_tvalid.
// One tag body byte per cycle while s_tready high; each yields at most one result.
// s_tready drops only while the four-entry result queue is full.
// Reset (synchronous, aresetn low) idles the parser, sets the NALU length size to
// four, clears profile and level, and empties the queue and output stage.
`default_nettype none
module flv_avc_video_tag_parser_core (
    input  wire           aclk,
    input  wire           aresetn,
    input  wire           s_tvalid,
    output logic          s_tready,
    // [7:0] data_byte, [31:8] tag_size, [63:32] tag_timestamp
    input  wire  [63:0]   s_tdata,
    // [0] first_of_tag
    input  wire           s_tuser,
    output logic          m_tvalid,
    input  wire           m_tready,
    // [23:0] nalu_length, [28:24] nal_type, [29] is_keyframe, [61:30] decode_time,
    // [85:62] comp_offset, [117:86] present_time, [125:118] profile,
    // [133:126] level, [136:134] prefix_size, [140:137] frame_type, [143:141] zero
    output logic [143:0]  m_tdata,
    // [2:0] kind
    output logic [2:0]    m_tuser
);
    import flvavc_pkg::*;
    `include "flv_avc_video_tag_parser_core_macros.svh"

    logic              in_xfer;
    logic              q_push;
    logic              q_pop;
    res_t              f_res;
    res_t              q_head;
    logic [QUEUE_AW:0] q_count;

    assign s_tready = (q_count != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign in_xfer  = s_tvalid && s_tready;

    flvavc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_xfer       (in_xfer),
        .data_byte     (s_tdata[7:0]),
        .first_of_tag  (s_tuser),
        .tag_size      (s_tdata[31:8]),
        .tag_timestamp (s_tdata[63:32]),
        .push          (q_push),
        .res           (f_res)
    );

    flvavc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (f_res),
        .pop     (q_pop),
        .rdata   (q_head),
        .count   (q_count)
    );

    flvavc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_nonempty (q_count != '0),
        .q_data     (q_head),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    `FLVAVC_ASSERT_IMP(a_push_room, aclk, aresetn, q_push, q_count != (QUEUE_AW + 1)'(QUEUE_DEPTH))
    `FLVAVC_ASSERT_NXT(a_reload, aclk, aresetn, m_tvalid && m_tready && (q_count != '0), m_tvalid)
    `FLVAVC_ASSERT_IMP(a_non_nalu_zero, aclk, aresetn, m_tvalid && (m_tuser != KIND_NALU), m_tdata[29:0] == 30'd0)
    `FLVAVC_ASSERT_IMP(a_key_idr, aclk, aresetn, m_tvalid && m_tdata[29], m_tdata[28:24] == IDR_TYPE)

endmodule
`default_nettype wire
